// File: rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types, codes and defaults for the text cell glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    // Defaults for the top level parameters.
    localparam int GLYPH_ROWS_DEF   = 16;
    localparam int CELL_WIDTH_DEF   = 9;
    localparam int TEXT_COLUMNS_DEF = 80;

    // The font always holds one glyph for every 8-bit code.
    localparam int FONT_GLYPHS = 256;
    localparam int FONT_BYTE_W = 8;

    // Configuration register map. Register i lies at byte address 4*i.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_TEXT_MODE      = 3'd0,
        REG_BYTES_PER_PIX  = 3'd1,
        REG_LINE_PITCH     = 3'd2,
        REG_SCREEN_WIDTH   = 3'd3,
        REG_CURSOR_VISIBLE = 3'd4,
        REG_CURSOR_COL     = 3'd5,
        REG_CURSOR_ROW     = 3'd6,
        REG_UNUSED         = 3'd7
    } reg_index_t;

    // Register reset values.
    localparam logic        RST_TEXT_MODE      = 1'b0;
    localparam logic [2:0]  RST_BYTES_PER_PIX  = 3'd4;
    localparam logic [15:0] RST_LINE_PITCH     = 16'd4096;
    localparam logic [11:0] RST_SCREEN_WIDTH   = 12'd1024;
    localparam logic        RST_CURSOR_VISIBLE = 1'b1;
    localparam logic [8:0]  RST_CURSOR_COL     = 9'd0;
    localparam logic [7:0]  RST_CURSOR_ROW     = 8'd0;

    // Input actions.
    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_RENDER = 1'b1
    } action_t;

    // Character codes with special handling.
    localparam logic [7:0] BOX_FIRST    = 8'hB0;
    localparam logic [7:0] BOX_LAST     = 8'hDF;
    localparam logic [7:0] REPLACE_CODE = 8'hFF;
    localparam logic [7:0] QMARK_CODE   = 8'h3F;

endpackage

// File: rtl/tcgr_font_ram.sv
// ----------------------------------------------------------------------------
// tcgr_font_ram
// Font store: one write port and one registered read port with enable.
// ----------------------------------------------------------------------------
module tcgr_font_ram #(
    parameter  int DEPTH  = tcgr_pkg::FONT_GLYPHS * tcgr_pkg::GLYPH_ROWS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [ADDR_W-1:0]                wr_addr,
    input  logic [tcgr_pkg::FONT_BYTE_W-1:0] wr_data,
    input  logic                             rd_en,
    input  logic [ADDR_W-1:0]                rd_addr,
    output logic [tcgr_pkg::FONT_BYTE_W-1:0] rd_data
);

    logic [tcgr_pkg::FONT_BYTE_W-1:0] mem [DEPTH];
    logic [tcgr_pkg::FONT_BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read in the same cycle as a write to the same entry returns the old byte.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/text_cell_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer
// Renders one character cell per render transaction from a loadable font.
// ----------------------------------------------------------------------------
// A load transaction writes one font byte. A render transaction in pixel mode
// yields GLYPH_ROWS results (16 by default), one per cycle while the output
// does not stall; in text mode a render yields one result. The row sequencer
// issues one glyph row per cycle, unless the output stalls, through the single
// read port of the font memory. The next transaction is accepted in the same
// cycle as the last row of the current cell is issued. A row is issued into
// the font read register and the stage 1 registers, which hold its address
// products, and then moves into the output register. A stalled output holds
// the whole pipeline, and nothing is lost or repeated. The font store is not
// cleared at reset; a glyph row that was never loaded renders as unknown.
module text_cell_glyph_renderer #(
    parameter int GLYPH_ROWS   = tcgr_pkg::GLYPH_ROWS_DEF,
    parameter int CELL_WIDTH   = tcgr_pkg::CELL_WIDTH_DEF,
    parameter int TEXT_COLUMNS = tcgr_pkg::TEXT_COLUMNS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcgr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tcgr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,

    // Input channel.
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [11:0]                     font_index,
    input  logic [7:0]                      font_byte,
    input  logic [8:0]                      cell_col,
    input  logic [7:0]                      cell_row,
    input  logic [7:0]                      char_code,
    input  logic [31:0]                     fg_color,
    input  logic [31:0]                     bg_color,
    input  logic [7:0]                      vga_attr,

    // Output channel.
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [31:0]                     byte_offset,
    output logic [8:0]                      fg_select,
    output logic [8:0]                      write_mask,
    output logic [31:0]                     fg_out,
    output logic [31:0]                     bg_out,
    output logic [7:0]                      text_code,
    output logic [7:0]                      text_attr,
    output logic                            last
);

    // Derived sizes.
    localparam int STORE_DEPTH = tcgr_pkg::FONT_GLYPHS * GLYPH_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(GLYPH_ROWS);
    // Pixel line number row*GLYPH_ROWS+i is below STORE_DEPTH.
    localparam int LINE_W      = ADDR_W;
    localparam int LPROD_W     = LINE_W + 16;
    localparam int CPROD_W     = 12;
    localparam int TIDX_W      = $clog2(256 * TEXT_COLUMNS + 512);

    // ------------------------------------------------------------------
    // Configuration registers. pready is always high, so a write lands
    // on the access cycle.
    // ------------------------------------------------------------------
    logic        text_mode_reg;
    logic [2:0]  bytes_per_pixel_reg;
    logic [15:0] line_pitch_reg;
    logic [11:0] screen_width_reg;
    logic        cursor_visible_reg;
    logic [8:0]  cursor_col_reg;
    logic [7:0]  cursor_row_reg;

    tcgr_pkg::reg_index_t cfg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = tcgr_pkg::reg_index_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_mode_reg       <= tcgr_pkg::RST_TEXT_MODE;
            bytes_per_pixel_reg <= tcgr_pkg::RST_BYTES_PER_PIX;
            line_pitch_reg      <= tcgr_pkg::RST_LINE_PITCH;
            screen_width_reg    <= tcgr_pkg::RST_SCREEN_WIDTH;
            cursor_visible_reg  <= tcgr_pkg::RST_CURSOR_VISIBLE;
            cursor_col_reg      <= tcgr_pkg::RST_CURSOR_COL;
            cursor_row_reg      <= tcgr_pkg::RST_CURSOR_ROW;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                tcgr_pkg::REG_TEXT_MODE:      text_mode_reg       <= pwdata[0];
                tcgr_pkg::REG_BYTES_PER_PIX:  bytes_per_pixel_reg <= pwdata[2:0];
                tcgr_pkg::REG_LINE_PITCH:     line_pitch_reg      <= pwdata[15:0];
                tcgr_pkg::REG_SCREEN_WIDTH:   screen_width_reg    <= pwdata[11:0];
                tcgr_pkg::REG_CURSOR_VISIBLE: cursor_visible_reg  <= pwdata[0];
                tcgr_pkg::REG_CURSOR_COL:     cursor_col_reg      <= pwdata[8:0];
                tcgr_pkg::REG_CURSOR_ROW:     cursor_row_reg      <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            tcgr_pkg::REG_TEXT_MODE:      prdata = {31'd0, text_mode_reg};
            tcgr_pkg::REG_BYTES_PER_PIX:  prdata = {29'd0, bytes_per_pixel_reg};
            tcgr_pkg::REG_LINE_PITCH:     prdata = {16'd0, line_pitch_reg};
            tcgr_pkg::REG_SCREEN_WIDTH:   prdata = {20'd0, screen_width_reg};
            tcgr_pkg::REG_CURSOR_VISIBLE: prdata = {31'd0, cursor_visible_reg};
            tcgr_pkg::REG_CURSOR_COL:     prdata = {23'd0, cursor_col_reg};
            tcgr_pkg::REG_CURSOR_ROW:     prdata = {24'd0, cursor_row_reg};
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline enable. Every stage moves when the output register is
    // empty or is being emptied in this cycle.
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic pipe_en;

    assign pipe_en = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Row sequencer (stage 0). It holds one render transaction and
    // issues its glyph rows one per cycle while the pipeline enable is high.
    // ------------------------------------------------------------------
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             seq_text_reg;
    logic [8:0]       seq_col_reg;
    logic [7:0]       seq_row_reg;
    logic [7:0]       seq_code_reg;
    logic [31:0]      seq_fg_reg;
    logic [31:0]      seq_bg_reg;
    logic [7:0]       seq_attr_reg;

    logic seq_last;
    logic in_accept;
    logic accept_render;
    logic accept_load;
    logic issue;

    // A text cell has a single row, so its first row is its last.
    assign seq_last      = seq_text_reg || (cnt_reg == CNT_W'(GLYPH_ROWS - 1));
    assign issue         = busy_reg && pipe_en;
    assign in_ready      = !busy_reg || (pipe_en && seq_last);
    assign in_accept     = in_valid && in_ready;
    assign accept_render = in_accept && (action == tcgr_pkg::ACT_RENDER);
    assign accept_load   = in_accept && (action == tcgr_pkg::ACT_LOAD);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (accept_render)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (issue)
        begin
            if (seq_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // The user must hold the text mode register stable while work is in flight;
    // the block does not enforce it. It is sampled per cell so a row knows its own format.
    always_ff @(posedge clk)
    begin
        if (accept_render)
        begin
            seq_text_reg <= text_mode_reg;
            seq_col_reg  <= cell_col;
            seq_row_reg  <= cell_row;
            seq_code_reg <= char_code;
            seq_fg_reg   <= fg_color;
            seq_bg_reg   <= bg_color;
            seq_attr_reg <= vga_attr;
        end
    end

    // ------------------------------------------------------------------
    // Font store. Loads write at acceptance. A row reads its glyph byte
    // at the edge where it is issued, which orders loads and renders as
    // they were accepted.
    // ------------------------------------------------------------------
    logic              font_wr_en;
    logic [ADDR_W-1:0] font_rd_addr;
    logic [7:0]        glyph_bits;

    assign font_wr_en   = accept_load && (32'(font_index) < 32'(STORE_DEPTH));
    assign font_rd_addr = ADDR_W'(32'(seq_code_reg) * GLYPH_ROWS + 32'(cnt_reg));

    tcgr_font_ram #(
        .DEPTH(STORE_DEPTH)
    ) u_font_ram (
        .clk     (clk),
        .wr_en   (font_wr_en),
        .wr_addr (ADDR_W'(font_index)),
        .wr_data (font_byte),
        .rd_en   (issue),
        .rd_addr (font_rd_addr),
        .rd_data (glyph_bits)
    );

    // ------------------------------------------------------------------
    // Stage 0 to 1: address products and per-row flags.
    // ------------------------------------------------------------------
    logic [LINE_W-1:0] line_num;
    logic              at_cursor;

    assign line_num  = LINE_W'(32'(seq_row_reg) * GLYPH_ROWS + 32'(cnt_reg));
    assign at_cursor = cursor_visible_reg && (seq_col_reg == cursor_col_reg)
                       && (seq_row_reg == cursor_row_reg);

    logic               s1_valid_reg;
    logic               s1_text_reg;
    logic               s1_last_reg;
    logic [LPROD_W-1:0] s1_line_prod_reg;
    logic [CPROD_W-1:0] s1_col_prod_reg;
    logic [TIDX_W-1:0]  s1_text_idx_reg;
    logic               s1_underline_reg;
    logic               s1_box_reg;
    logic               s1_ninth_ok_reg;
    logic [7:0]         s1_code_reg;
    logic [7:0]         s1_attr_reg;
    logic [31:0]        s1_fg_reg;
    logic [31:0]        s1_bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_text_reg      <= seq_text_reg;
            s1_last_reg      <= seq_last;
            s1_line_prod_reg <= LPROD_W'(line_num) * LPROD_W'(line_pitch_reg);
            s1_col_prod_reg  <= CPROD_W'(seq_col_reg) * CPROD_W'(bytes_per_pixel_reg);
            s1_text_idx_reg  <= TIDX_W'(32'(seq_row_reg) * TEXT_COLUMNS
                                        + 32'(seq_col_reg));
            s1_underline_reg <= at_cursor && (32'(cnt_reg) >= GLYPH_ROWS - 2);
            s1_box_reg       <= (seq_code_reg >= tcgr_pkg::BOX_FIRST)
                                && (seq_code_reg <= tcgr_pkg::BOX_LAST);
            s1_ninth_ok_reg  <= (CELL_WIDTH > 8)
                                && ((32'(seq_col_reg) + 32'd1) * CELL_WIDTH
                                    <= 32'(screen_width_reg));
            s1_code_reg      <= seq_code_reg;
            s1_attr_reg      <= seq_attr_reg;
            s1_fg_reg        <= seq_fg_reg;
            s1_bg_reg        <= seq_bg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 to output: offset sum, pixel masks and text fields.
    // ------------------------------------------------------------------
    logic        fg_vis;
    logic        bg_vis;
    logic [8:0]  sel_c;
    logic [8:0]  mask_c;
    logic [31:0] offset_c;
    logic [7:0]  tcode_c;
    logic [7:0]  tattr_c;

    assign fg_vis = |s1_fg_reg[31:24];
    assign bg_vis = |s1_bg_reg[31:24];

    always_comb
    begin
        sel_c  = '0;
        mask_c = '0;
        for (int j = 0; j < 8; j++)
        begin
            sel_c[j]  = glyph_bits[7-j] || s1_underline_reg;
            mask_c[j] = sel_c[j] ? fg_vis : bg_vis;
        end
        if (CELL_WIDTH > 8)
        begin
            sel_c[8]  = s1_box_reg && glyph_bits[0];
            mask_c[8] = s1_ninth_ok_reg && (sel_c[8] ? fg_vis : bg_vis);
        end
    end

    always_comb
    begin
        tcode_c = s1_code_reg;
        tattr_c = s1_attr_reg;
        if (s1_code_reg == tcgr_pkg::REPLACE_CODE)
        begin
            tcode_c = tcgr_pkg::QMARK_CODE;
            tattr_c = {s1_attr_reg[3:0], s1_attr_reg[7:4]};
        end
    end

    always_comb
    begin
        if (s1_text_reg)
        begin
            offset_c = 32'({s1_text_idx_reg, 1'b0});
        end
        else
        begin
            offset_c = 32'(s1_line_prod_reg) + 32'(s1_col_prod_reg) * CELL_WIDTH;
        end
    end

    logic [31:0] out_offset_reg;
    logic [8:0]  out_sel_reg;
    logic [8:0]  out_mask_reg;
    logic [31:0] out_fg_reg;
    logic [31:0] out_bg_reg;
    logic [7:0]  out_code_reg;
    logic [7:0]  out_attr_reg;
    logic        out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && s1_valid_reg)
        begin
            out_offset_reg <= offset_c;
            out_last_reg   <= s1_last_reg;
            if (s1_text_reg)
            begin
                out_sel_reg  <= '0;
                out_mask_reg <= '0;
                out_fg_reg   <= '0;
                out_bg_reg   <= '0;
                out_code_reg <= tcode_c;
                out_attr_reg <= tattr_c;
            end
            else
            begin
                out_sel_reg  <= sel_c;
                out_mask_reg <= mask_c;
                out_fg_reg   <= s1_fg_reg;
                out_bg_reg   <= s1_bg_reg;
                out_code_reg <= '0;
                out_attr_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_offset = out_offset_reg;
    assign fg_select   = out_sel_reg;
    assign write_mask  = out_mask_reg;
    assign fg_out      = out_fg_reg;
    assign bg_out      = out_bg_reg;
    assign text_code   = out_code_reg;
    assign text_attr   = out_attr_reg;
    assign last        = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // While a cell is in progress, a new transaction is only taken as its
    // last row leaves the sequencer.
    a_ready_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && in_ready |-> pipe_en && seq_last)
        else $error("input accepted while a cell still has rows to issue");

    // The row counter stays within the glyph.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (32'(cnt_reg) <= GLYPH_ROWS - 1))
        else $error("row counter past the last glyph row");

    // A text cell never advances past its single row.
    a_text_single_row: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && seq_text_reg |-> cnt_reg == '0)
        else $error("text cell issued more than one row");

    // A row waiting in stage 1 is not dropped while the output stalls.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !pipe_en |=> s1_valid_reg && out_valid_reg)
        else $error("stage 1 row lost during an output stall");

endmodule

// File: tb/tb_text_cell_glyph_renderer.sv
// ----------------------------------------------------------------------------
// tb_text_cell_glyph_renderer
// Self-checking testbench for the text cell glyph renderer.
// ----------------------------------------------------------------------------
// The bench loads glyphs into the font memory, then renders cells in pixel
// and text mode under several register settings. It uses directed cells for
// the corner cases and then random traffic with varied idling on both
// channels. A scoreboard class keeps its own font image and register copy,
// predicts every glyph row or text cell, and compares each output
// transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb_text_cell_glyph_renderer;
    timeunit 1ns;
    timeprecision 1ps;

    import tcgr_pkg::*;

    localparam int ROWS        = GLYPH_ROWS_DEF;
    localparam int CELL_W      = CELL_WIDTH_DEF;
    localparam int COLS        = TEXT_COLUMNS_DEF;
    localparam int STORE_DEPTH = FONT_GLYPHS * ROWS;

    // Wait after the last row is out, long enough for a trailing load
    // transaction to retire.
    localparam int SETTLE_CYCLES = 8;
    // Length of the deliberate receiver hold-off, in clock cycles.
    localparam int LONG_HOLD = 300;
    // Cycles without any accepted transaction before the run is declared hung.
    // The longest legal quiet stretch is the long hold plus a random stall tail.
    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 9;

    // One input transaction, as the block sees it on its input channel.
    typedef struct packed {
        action_t     action;
        logic [11:0] font_index;
        logic [7:0]  font_byte;
        logic [8:0]  cell_col;
        logic [7:0]  cell_row;
        logic [7:0]  char_code;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic [7:0]  vga_attr;
    } cell_txn_t;

    // One output transaction: a glyph row in pixel mode or a text cell.
    typedef struct packed {
        logic [31:0] byte_offset;
        logic [8:0]  fg_select;
        logic [8:0]  write_mask;
        logic [31:0] fg_out;
        logic [31:0] bg_out;
        logic [7:0]  text_code;
        logic [7:0]  text_attr;
        logic        last;
    } row_txn_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the font and register state of the block and holds
    // the glyph rows that are still due on the output channel.
    // ------------------------------------------------------------------------
    class glyph_row_board;
        logic        text_mode;
        logic [2:0]  bytes_per_pixel;
        logic [15:0] line_pitch;
        logic [11:0] screen_width;
        logic        cursor_visible;
        logic [8:0]  cursor_col;
        logic [7:0]  cursor_row;
        bit   [7:0]  font_rows [STORE_DEPTH];
        row_txn_t    rows_due [$];
        int          errors;

        function new();
            text_mode       = RST_TEXT_MODE;
            bytes_per_pixel = RST_BYTES_PER_PIX;
            line_pitch      = RST_LINE_PITCH;
            screen_width    = RST_SCREEN_WIDTH;
            cursor_visible  = RST_CURSOR_VISIBLE;
            cursor_col      = RST_CURSOR_COL;
            cursor_row      = RST_CURSOR_ROW;
            errors          = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [31:0] value);
            case (idx)
                REG_TEXT_MODE:      text_mode       = value[0];
                REG_BYTES_PER_PIX:  bytes_per_pixel = value[2:0];
                REG_LINE_PITCH:     line_pitch      = value[15:0];
                REG_SCREEN_WIDTH:   screen_width    = value[11:0];
                REG_CURSOR_VISIBLE: cursor_visible  = value[0];
                REG_CURSOR_COL:     cursor_col      = value[8:0];
                REG_CURSOR_ROW:     cursor_row      = value[7:0];
                default: ;
            endcase
        endfunction

        // Takes one accepted input transaction and queues the rows it yields.
        function void note_cell(cell_txn_t c);
            row_txn_t    r;
            logic [31:0] base;
            logic [7:0]  bits;
            logic        at_cursor;
            logic        box;
            logic        ninth_ok;
            logic        under;
            logic        f;

            if (c.action == ACT_LOAD)
            begin
                font_rows[c.font_index] = c.font_byte;
                return;
            end

            r = '0;
            if (text_mode)
            begin
                r.byte_offset = 2 * (32'(c.cell_row) * COLS + 32'(c.cell_col));
                if (c.char_code == REPLACE_CODE)
                begin
                    r.text_code = QMARK_CODE;
                    r.text_attr = {c.vga_attr[3:0], c.vga_attr[7:4]};
                end
                else
                begin
                    r.text_code = c.char_code;
                    r.text_attr = c.vga_attr;
                end
                r.last = 1'b1;
                rows_due.push_back(r);
                return;
            end

            base = 32'(c.cell_row) * ROWS * 32'(line_pitch) +
                   32'(c.cell_col) * CELL_W * 32'(bytes_per_pixel);
            at_cursor = cursor_visible && c.cell_col == cursor_col &&
                        c.cell_row == cursor_row;
            box = c.char_code >= BOX_FIRST && c.char_code <= BOX_LAST;
            ninth_ok = (CELL_W > 8) &&
                       ((32'(c.cell_col) + 1) * CELL_W <= 32'(screen_width));

            for (int i = 0; i < ROWS; i++)
            begin
                bits  = font_rows[(32'(c.char_code) * ROWS + i) % STORE_DEPTH];
                under = at_cursor && i >= ROWS - 2;
                r = '0;
                for (int j = 0; j < 8; j++)
                begin
                    f = bits[7 - j] || under;
                    r.fg_select[j]  = f;
                    r.write_mask[j] = f ? (c.fg_color[31:24] != 8'h00)
                                        : (c.bg_color[31:24] != 8'h00);
                end
                if (CELL_W > 8)
                begin
                    f = box && bits[0];
                    r.fg_select[8]  = f;
                    r.write_mask[8] = ninth_ok &&
                                      (f ? (c.fg_color[31:24] != 8'h00)
                                         : (c.bg_color[31:24] != 8'h00));
                end
                r.byte_offset = base + 32'(i) * 32'(line_pitch);
                r.fg_out      = c.fg_color;
                r.bg_out      = c.bg_color;
                r.last        = (i == ROWS - 1);
                rows_due.push_back(r);
            end
        endfunction

        function void field_ok(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        // Compares one output transaction with the oldest row still due.
        function void check_row(row_txn_t got);
            row_txn_t want;
            if (rows_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual offset %h last %b",
                         $time, got.byte_offset, got.last);
                return;
            end
            want = rows_due.pop_front();
            field_ok("byte_offset", want.byte_offset,     got.byte_offset);
            field_ok("fg_select",   32'(want.fg_select),  32'(got.fg_select));
            field_ok("write_mask",  32'(want.write_mask), 32'(got.write_mask));
            field_ok("fg_out",      want.fg_out,          got.fg_out);
            field_ok("bg_out",      want.bg_out,          got.bg_out);
            field_ok("text_code",   32'(want.text_code),  32'(got.text_code));
            field_ok("text_attr",   32'(want.text_attr),  32'(got.text_attr));
            field_ok("last",        32'(want.last),       32'(got.last));
        endfunction

        function int pending();
            return rows_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every block input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  action     = 1'b0;
    logic [11:0]           font_index = '0;
    logic [7:0]            font_byte  = '0;
    logic [8:0]            cell_col   = '0;
    logic [7:0]            cell_row   = '0;
    logic [7:0]            char_code  = '0;
    logic [31:0]           fg_color   = '0;
    logic [31:0]           bg_color   = '0;
    logic [7:0]            vga_attr   = '0;

    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [31:0]           byte_offset;
    logic [8:0]            fg_select;
    logic [8:0]            write_mask;
    logic [31:0]           fg_out;
    logic [31:0]           bg_out;
    logic [7:0]            text_code;
    logic [7:0]            text_attr;
    logic                  last;

    // Idling controls, written only by the main sequence.
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_asked   = 0;

    // The bench's own record of which font rows hold defined data. A pixel
    // render is only ever issued for a glyph whose sixteen rows were loaded.
    bit row_loaded [STORE_DEPTH];
    bit code_ready [FONT_GLYPHS];
    int ready_codes [$];

    glyph_row_board board;

    text_cell_glyph_renderer dut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls at the chosen rate, plus one long hold-off on
    // request. The hold is counted here so the sender keeps running freely
    // and the block has to back up and stall its input.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_seen)
            begin
                hold_seen = hold_asked;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted transaction on either channel goes to the
    // scoreboard. Values are read at the clock edge, before the block's own
    // registers update, so they are the ones the block sampled.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : observe
        cell_txn_t c;
        row_txn_t  r;
        if (rst_n && out_valid && out_ready)
        begin
            r.byte_offset = byte_offset;
            r.fg_select   = fg_select;
            r.write_mask  = write_mask;
            r.fg_out      = fg_out;
            r.bg_out      = bg_out;
            r.text_code   = text_code;
            r.text_attr   = text_attr;
            r.last        = last;
            board.check_row(r);
        end
        if (rst_n && in_valid && in_ready)
        begin
            c.action     = action_t'(action);
            c.font_index = font_index;
            c.font_byte  = font_byte;
            c.cell_col   = cell_col;
            c.cell_row   = cell_row;
            c.char_code  = char_code;
            c.fg_color   = fg_color;
            c.bg_color   = bg_color;
            c.vga_attr   = vga_attr;
            board.note_cell(c);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no transaction has been accepted on either
    // channel for too long, which also catches rows that never arrive.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Configuration port. Consecutive writes run back to back, so psel stays
    // high between them; the caller drops it after the last one.
    // ------------------------------------------------------------------------
    task automatic apb_write(reg_index_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        board.write_reg(idx, value);
    endtask

    task automatic program_all(logic tm, logic [2:0] bpp, logic [15:0] pitch,
                               logic [11:0] width, logic cv, logic [8:0] ccol,
                               logic [7:0] crow);
        apb_write(REG_TEXT_MODE,      32'(tm));
        apb_write(REG_BYTES_PER_PIX,  32'(bpp));
        apb_write(REG_LINE_PITCH,     32'(pitch));
        apb_write(REG_SCREEN_WIDTH,   32'(width));
        apb_write(REG_CURSOR_VISIBLE, 32'(cv));
        apb_write(REG_CURSOR_COL,     32'(ccol));
        apb_write(REG_CURSOR_ROW,     32'(crow));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Input channel. Valid is only lowered during a gap, so a transaction
    // that follows straight on keeps valid high without a second assignment
    // in the same time step.
    // ------------------------------------------------------------------------
    task automatic send_cell(cell_txn_t c);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= c.action;
        font_index <= c.font_index;
        font_byte  <= c.font_byte;
        cell_col   <= c.cell_col;
        cell_row   <= c.cell_row;
        char_code  <= c.char_code;
        fg_color   <= c.fg_color;
        bg_color   <= c.bg_color;
        vga_attr   <= c.vga_attr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Fields that the action does not use still carry random bits.
    function automatic cell_txn_t random_fields();
        cell_txn_t c;
        c.action     = action_t'($urandom_range(1));
        c.font_index = 12'($urandom);
        c.font_byte  = 8'($urandom);
        c.cell_col   = 9'($urandom);
        c.cell_row   = 8'($urandom);
        c.char_code  = 8'($urandom);
        c.fg_color   = $urandom;
        c.bg_color   = $urandom;
        c.vga_attr   = 8'($urandom);
        return c;
    endfunction

    function automatic bit glyph_complete(int code);
        for (int r = 0; r < ROWS; r++)
            if (!row_loaded[code * ROWS + r]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_load(logic [11:0] addr, logic [7:0] value);
        cell_txn_t c;
        int        code;
        c = random_fields();
        c.action     = ACT_LOAD;
        c.font_index = addr;
        c.font_byte  = value;
        send_cell(c);
        row_loaded[addr] = 1'b1;
        code = int'(addr) / ROWS;
        if (!code_ready[code] && glyph_complete(code))
        begin
            code_ready[code] = 1'b1;
            ready_codes.push_back(code);
        end
    endtask

    // Loads all rows of one glyph; blank and solid rows turn up often.
    task automatic load_glyph(int code);
        logic [7:0] value;
        for (int r = 0; r < ROWS; r++)
        begin
            case ($urandom_range(7))
                0:       value = 8'h00;
                1:       value = 8'hFF;
                default: value = 8'($urandom);
            endcase
            send_load(12'(code * ROWS + r), value);
        end
    endtask

    task automatic send_render(logic [7:0] code, logic [8:0] col, logic [7:0] row,
                               logic [31:0] fg, logic [31:0] bg, logic [7:0] attr);
        cell_txn_t c;
        c = random_fields();
        c.action    = ACT_RENDER;
        c.char_code = code;
        c.cell_col  = col;
        c.cell_row  = row;
        c.fg_color  = fg;
        c.bg_color  = bg;
        c.vga_attr  = attr;
        send_cell(c);
    endtask

    // Lowers valid after the last transaction, waits until every expected
    // row has come out, then lets a trailing load retire before the caller
    // touches the registers. The first edge also lets the monitor record
    // the final input transaction before the queue is inspected.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic. Most transactions are renders, in pixel mode only of
    // glyphs already in the font; the rest reload whole glyphs or scribble single font rows.
    // Renders favor the cursor cell and the columns around the clip edge.
    // ------------------------------------------------------------------------
    task automatic run_random(int count);
        int          sent;
        int          pick;
        int          code;
        int          col;
        int          row;
        logic [31:0] fg;
        logic [31:0] bg;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                load_glyph($urandom_range(FONT_GLYPHS - 1));
                sent += ROWS;
            end
            else if (pick < 14)
            begin
                send_load(12'($urandom_range(STORE_DEPTH - 1)), 8'($urandom));
                sent++;
            end
            else
            begin
                // Text mode output does not use the font, so any code may be sent.
                if (board.text_mode)
                    code = ($urandom_range(5) == 0) ? int'(REPLACE_CODE)
                                                    : $urandom_range(255);
                else
                    code = ready_codes[$urandom_range(ready_codes.size() - 1)];
                col = $urandom_range(511);
                row = $urandom_range(255);
                case ($urandom_range(3))
                    0:
                    begin
                        col = board.cursor_col;
                        row = board.cursor_row;
                    end
                    1: col = (int'(board.screen_width) / CELL_W +
                              int'($urandom_range(1)) - 1) & 511;
                    default: ;
                endcase
                fg = $urandom;
                bg = $urandom;
                if ($urandom_range(4) == 0) fg[31:24] = 8'h00;
                if ($urandom_range(4) == 0) bg[31:24] = 8'h00;
                send_render(8'(code), 9'(col), 8'(row), fg, bg, 8'($urandom));
                sent++;
            end
        end
    endtask

    task automatic random_phase(idle_mode_t mode, logic tm, logic [2:0] bpp,
                                logic [15:0] pitch, logic [11:0] width, logic cv,
                                logic [8:0] ccol, logic [7:0] crow, bit long_hold);
        // The sender has paused and every expected row has come out.
        drain();
        program_all(tm, bpp, pitch, width, cv, ccol, crow);
        case (mode)
            IDLE_SENDER:
            begin
                send_gap_pct = 83;
                stall_pct    = 0;
            end
            IDLE_RECEIVER:
            begin
                send_gap_pct = 0;
                stall_pct    = 83;
            end
            IDLE_BOTH:
            begin
                send_gap_pct = 11;
                stall_pct    = 11;
            end
            default:
            begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
        endcase
        if (long_hold) hold_asked++;
        run_random(ITEMS_PER_PHASE);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main
        logic [7:0] seed_codes [6];

        board = new();
        seed_codes = '{8'h41, 8'hAF, BOX_FIRST, BOX_LAST, 8'hE0, REPLACE_CODE};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Font setup under the reset register values: glyphs around the box
        // drawing range, the top of the code space, and an ordinary letter.
        foreach (seed_codes[k]) load_glyph(seed_codes[k]);
        send_load(12'(STORE_DEPTH - 1), 8'hFF);

        // Directed cells with the reset values: cursor at the origin and
        // visible, 1024 pixels wide, four bytes per pixel.
        send_render(8'h41, 9'd0, 8'd0, 32'hFFFFFFFF, 32'hFF000000, 8'h07);
        send_render(BOX_FIRST, 9'd1, 8'd0, 32'h80112233, 32'h01445566, 8'h07);
        // Last column whose ninth dot still fits, then the first one clipped.
        send_render(BOX_LAST, 9'd112, 8'd3, 32'hFFFFFFFF, 32'hFF000000, 8'h07);
        send_render(BOX_LAST, 9'd113, 8'd3, 32'hFFFFFFFF, 32'hFF000000, 8'h07);
        // Codes just outside the box drawing range never copy the ninth dot.
        send_render(8'hAF, 9'd5, 8'd5, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h07);
        send_render(8'hE0, 9'd6, 8'd5, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h07);
        send_render(REPLACE_CODE, 9'd7, 8'd5, 32'hFF00FF00, 32'hFF0000FF, 8'h07);
        // Transparent foreground, then transparent background.
        send_render(8'h41, 9'd8, 8'd9, 32'h00FFFFFF, 32'hFF000000, 8'h07);
        send_render(BOX_LAST, 9'd8, 8'd9, 32'hFFFFFFFF, 32'h00000000, 8'h07);
        send_render(8'h41, 9'd511, 8'd255, 32'hFFFFFFFF, 32'hFF000000, 8'h07);

        // Widest screen, largest pitch, three bytes per pixel, cursor hidden
        // at the far corner.
        drain();
        program_all(1'b0, 3'd3, 16'hFFFF, 12'd4095, 1'b0, 9'd511, 8'd255);
        send_render(BOX_FIRST, 9'd511, 8'd255, 32'hFFFFFFFF, 32'hFF000000, 8'h07);
        send_render(8'h41, 9'd454, 8'd255, 32'hFFFFFFFF, 32'hFF000000, 8'h07);

        // Same corner with the cursor shown, then odd bytes per pixel with a
        // zero pitch and zero width, which clips every ninth dot.
        drain();
        program_all(1'b0, 3'd4, 16'hFFFF, 12'd4095, 1'b1, 9'd511, 8'd255);
        send_render(BOX_LAST, 9'd511, 8'd255, 32'hFFFFFFFF, 32'hFF000000, 8'h07);
        drain();
        program_all(1'b0, 3'd7, 16'd0, 12'd0, 1'b1, 9'd10, 8'd10);
        send_render(BOX_FIRST, 9'd10, 8'd10, 32'hFFFFFFFF, 32'hFF000000, 8'h07);

        // Text mode: replacement code with nibble swap, the cursor cell
        // rendered like any other, the largest cell position, and a load
        // transaction that yields nothing.
        drain();
        program_all(1'b1, 3'd4, 16'd4096, 12'd1024, 1'b1, 9'd3, 8'd2);
        send_render(REPLACE_CODE, 9'd0, 8'd0, '0, '0, 8'h5A);
        send_render(QMARK_CODE, 9'd1, 8'd0, '0, '0, 8'h0F);
        send_render(8'h00, 9'd511, 8'd255, '0, '0, 8'hF0);
        send_render(8'h41, 9'd3, 8'd2, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h1E);
        send_render(REPLACE_CODE, 9'd4, 8'd2, '0, '0, 8'hFF);
        send_load(12'd0, seed_codes[0]);
        send_render(REPLACE_CODE, 9'd5, 8'd2, '0, '0, 8'h00);

        // Random phases across register settings and idling patterns. The
        // fifth phase holds the receiver off while the sender keeps going.
        random_phase(IDLE_NONE, 1'b0, 3'd4, 16'd4096, 12'd1024, 1'b1,
                     9'($urandom), 8'($urandom), 1'b0);
        random_phase(IDLE_SENDER, 1'b0, 3'd3, 16'd0, 12'd0, 1'b1,
                     9'($urandom), 8'($urandom), 1'b0);
        random_phase(IDLE_RECEIVER, 1'b1, 3'd3, 16'($urandom), 12'($urandom), 1'b1,
                     9'($urandom), 8'($urandom), 1'b0);
        random_phase(IDLE_BOTH, 1'b0, 3'($urandom), 16'($urandom), 12'($urandom),
                     1'($urandom), 9'($urandom), 8'($urandom), 1'b0);
        random_phase(IDLE_NONE, 1'b0, 3'd4, 16'hFFFF, 12'd4095, 1'b1,
                     9'd511, 8'd255, 1'b1);
        random_phase(IDLE_BOTH, 1'b1, 3'd4, 16'd4096, 12'd1024, 1'b0,
                     9'($urandom), 8'($urandom), 1'b0);
        random_phase(IDLE_SENDER, 1'b0, 3'($urandom), 16'($urandom), 12'($urandom),
                     1'b1, 9'($urandom), 8'($urandom), 1'b0);

        drain();
        if (board.errors == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
rtl/tcgr_pkg.sv
rtl/tcgr_font_ram.sv
rtl/text_cell_glyph_renderer.sv
tb/tb_text_cell_glyph_renderer.sv
